// ===== sv/stq_pkg.sv =====
`timescale 1ns / 1ps
package stq_pkg;

	localparam int SLOTS     = 16;
	localparam int SLOT_BITS = 4;
	localparam int TIME_BITS = 32;
	localparam int DELTA_BITS = 24;
	localparam int MAX_OUT   = 16;
	localparam int CNT_BITS  = 5;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_REMOVE,
		CMD_INSERT
	} cell_cmd_t;

	// one queue entry held by a cell
	typedef struct packed {
		logic                 valid;
		logic [SLOT_BITS-1:0] slot;
		logic [TIME_BITS-1:0] trig;
	} entry_t;

	// broadcast control to every cell
	typedef struct packed {
		cell_cmd_t            cmd;
		logic [SLOT_BITS-1:0] key_slot;
		entry_t               ins;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_REINS,
		ST_FLUSH,
		ST_REMOVE,
		ST_INSERT,
		ST_READ
	} state_t;

endpackage

// ===== sv/sorted_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// Sorted timer queue unit.
// Input channel (in_valid/in_stall) carries one command beat: opcode, slot,
// delta, repeat_req. Output channel (out_valid/out_stall) carries result
// beats: kind, fired_slot, time_value, last.
// Armed slots live in a row of cells sorted by trigger time; each cell
// shifts left or right one place per cycle on remove or insert.
// Steps per command: start removes any old entry, then inserts; stop
// only removes; read goes to the output register. Tick advances time,
// removes each due slot in turn, re-inserting a repeating one, then a
// head check finds nothing due and the held beat goes out.
// A command is taken only while the unit is idle; in_stall is high
// otherwise. Results pass through one output register, so the last beat
// of a command may still wait while the next command is accepted.
// Each fired beat is held one step so that last can be set on the final one.
// A stalled receiver freezes the tick sequence until the register frees.
// Reset clears time, all slots and the queue, and drops a command in
// progress and any result beat in the output register.
module sorted_timer_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [23:0] delta,
	input  logic        repeat_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [3:0]  fired_slot,
	output logic [31:0] time_value,
	output logic        last
);

	localparam int S  = stq_pkg::SLOTS;
	localparam int SB = stq_pkg::SLOT_BITS;
	localparam int TB = stq_pkg::TIME_BITS;

	stq_pkg::state_t state_q, state_d;
	stq_pkg::opcode_t op_q;
	logic [SB-1:0]    slot_q;
	logic [stq_pkg::DELTA_BITS-1:0] delta_q;
	logic             rep_q;
	logic [TB-1:0]    now_q;
	logic [S-1:0]     fired_q;
	logic [stq_pkg::CNT_BITS-1:0] cnt_q;
	logic             pend_valid_q;
	logic [SB-1:0]    pend_slot_q;
	logic [TB-1:0]    rtrig_q;
	logic [S-1:0]     armed_q;
	logic [S-1:0]     rep_arr_q;
	logic [stq_pkg::DELTA_BITS-1:0] per_q [S];

	logic             out_valid_q, kind_q, last_q;
	logic [SB-1:0]    out_slot_q;
	logic [31:0]      out_time_q;

	stq_pkg::cell_ctl_t ctl;
	stq_pkg::entry_t    ents [S];
	logic [S-1:0]       keep, match;

	// cell row
	genvar gi;
	generate
		for (gi = 0; gi < S; gi++) begin : g_cell
			stq_pkg::entry_t lft, rgt;
			if (gi == 0) begin : g_first
				assign lft = '0;
			end else begin : g_mid
				assign lft = ents[gi-1];
			end
			if (gi == S - 1) begin : g_last
				assign rgt = '0;
			end else begin : g_body
				assign rgt = ents[gi+1];
			end
			stq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.left     (lft),
				.right    (rgt),
				.keep_in  ((gi == 0) ? 1'b1 : keep[(gi == 0) ? 0 : gi-1]),
				.match_in ((gi == 0) ? 1'b0 : match[(gi == 0) ? 0 : gi-1]),
				.ent      (ents[gi]),
				.keep_out (keep[gi]),
				.match_out(match[gi])
			);
		end
	endgenerate

	// sequencer decisions
	stq_pkg::entry_t head;
	logic out_free, head_due, accept;
	logic push, push_kind, push_last, pop, pop_rep;
	logic [SB-1:0] push_slot;

	assign head     = ents[0];
	assign out_free = !out_valid_q || !out_stall;
	assign head_due = head.valid && !fired_q[head.slot] && (head.trig <= now_q)
		&& (cnt_q < stq_pkg::CNT_BITS'(stq_pkg::MAX_OUT));
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != stq_pkg::ST_IDLE);

	always_comb begin
		state_d   = state_q;
		ctl.cmd   = stq_pkg::CMD_HOLD;
		ctl.key_slot = slot_q;
		ctl.ins.valid = 1'b1;
		ctl.ins.slot  = slot_q;
		ctl.ins.trig  = now_q + TB'(delta_q);
		push      = 1'b0;
		push_kind = 1'b0;
		push_last = 1'b0;
		push_slot = pend_slot_q;
		pop       = 1'b0;
		pop_rep   = rep_arr_q[head.slot];
		case (state_q)
			stq_pkg::ST_IDLE: begin
				if (accept) begin
					case (stq_pkg::opcode_t'(opcode))
						stq_pkg::OP_TICK:  state_d = stq_pkg::ST_POP;
						stq_pkg::OP_READ:  state_d = stq_pkg::ST_READ;
						default:           state_d = stq_pkg::ST_REMOVE;
					endcase
				end
			end
			stq_pkg::ST_POP: begin
				ctl.key_slot = head.slot;
				if (head_due) begin
					if (!pend_valid_q || out_free) begin
						push = pend_valid_q;
						pop  = 1'b1;
						ctl.cmd = stq_pkg::CMD_REMOVE;
						if (pop_rep) state_d = stq_pkg::ST_REINS;
					end
				end else begin
					state_d = stq_pkg::ST_FLUSH;
				end
			end
			stq_pkg::ST_REINS: begin
				ctl.cmd      = stq_pkg::CMD_INSERT;
				ctl.ins.slot = pend_slot_q;
				ctl.ins.trig = rtrig_q;
				state_d      = stq_pkg::ST_POP;
			end
			stq_pkg::ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = stq_pkg::ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = stq_pkg::ST_IDLE;
				end
			end
			stq_pkg::ST_REMOVE: begin
				ctl.cmd = stq_pkg::CMD_REMOVE;
				state_d = (op_q == stq_pkg::OP_START) ? stq_pkg::ST_INSERT : stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_INSERT: begin
				ctl.cmd = stq_pkg::CMD_INSERT;
				state_d = stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_READ: begin
				if (out_free) begin
					push      = 1'b1;
					push_kind = 1'b1;
					push_last = 1'b1;
					push_slot = '0;
					state_d   = stq_pkg::ST_IDLE;
				end
			end
			default: state_d = stq_pkg::ST_IDLE;
		endcase
	end

	// control and slot settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= stq_pkg::ST_IDLE;
			op_q         <= stq_pkg::OP_TICK;
			slot_q       <= '0;
			delta_q      <= '0;
			rep_q        <= 1'b0;
			now_q        <= '0;
			fired_q      <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			rtrig_q      <= '0;
			armed_q      <= '0;
			rep_arr_q    <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < S; i++) per_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q    <= stq_pkg::opcode_t'(opcode);
				slot_q  <= slot;
				delta_q <= delta;
				rep_q   <= repeat_req;
				if (stq_pkg::opcode_t'(opcode) == stq_pkg::OP_TICK) begin
					now_q   <= now_q + TB'(1);
					fired_q <= '0;
					cnt_q   <= '0;
				end
			end
			if (pop) begin
				fired_q[head.slot] <= 1'b1;
				cnt_q        <= cnt_q + stq_pkg::CNT_BITS'(1);
				pend_valid_q <= 1'b1;
				pend_slot_q  <= head.slot;
				rtrig_q      <= head.trig + TB'(per_q[head.slot]);
				if (!pop_rep) armed_q[head.slot] <= 1'b0;
			end else if (state_q == stq_pkg::ST_FLUSH && push) begin
				pend_valid_q <= 1'b0;
			end
			if (state_q == stq_pkg::ST_REMOVE && op_q == stq_pkg::OP_STOP)
				armed_q[slot_q] <= 1'b0;
			if (state_q == stq_pkg::ST_INSERT) begin
				armed_q[slot_q]   <= 1'b1;
				rep_arr_q[slot_q] <= rep_q;
				per_q[slot_q]     <= delta_q;
			end
			// output register
			if (push) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q     <= push_kind;
			out_slot_q <= push_slot;
			out_time_q <= now_q[31:0];
			last_q     <= push_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign fired_slot = out_slot_q;
	assign time_value = out_time_q;
	assign last       = last_q;

	// checks
	a_fired_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != stq_pkg::ST_IDLE) |-> ($countones(fired_q) == 32'(cnt_q)))
		else $error("fired mask and count disagree");
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (cnt_q != '0))
		else $error("held beat without fired slot");
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(ents[0].valid && ents[1].valid) |-> (ents[0].trig <= ents[1].trig))
		else $error("queue head out of order");

endmodule

// ===== sv/stq_cell.sv =====
`timescale 1ns / 1ps
module stq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  stq_pkg::cell_ctl_t ctl,
	input  stq_pkg::entry_t   left,
	input  stq_pkg::entry_t   right,
	input  logic              keep_in,
	input  logic              match_in,
	output stq_pkg::entry_t   ent,
	output logic              keep_out,
	output logic              match_out
);

	stq_pkg::entry_t ent_q;

	// chain terms: keep is a prefix of entries not later than the new one,
	// match marks the removed entry and everything behind it
	assign keep_out  = ent_q.valid && (ent_q.trig <= ctl.ins.trig);
	assign match_out = match_in || (ent_q.valid && (ent_q.slot == ctl.key_slot));
	assign ent       = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.valid <= 1'b0;
			ent_q.slot  <= '0;
			ent_q.trig  <= '0;
		end else begin
			case (ctl.cmd)
				stq_pkg::CMD_REMOVE: begin
					if (match_out) ent_q <= right;
				end
				stq_pkg::CMD_INSERT: begin
					if (!keep_out) begin
						if (keep_in) ent_q <= ctl.ins;
						else ent_q <= left;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	// one result beat of the timer unit
	typedef struct packed {
		logic        kind;
		logic [3:0]  fired_slot;
		logic [31:0] time_value;
		logic        last;
	} timer_beat_t;

	// Timer queue tracker: mirrors the armed slots and checks result beats.
	class timer_scoreboard;
		logic [31:0] now;
		logic [31:0] trig [stq_pkg::SLOTS];
		logic [23:0] per [stq_pkg::SLOTS];
		bit          rep [stq_pkg::SLOTS];
		bit          armed [stq_pkg::SLOTS];
		int          order [$];
		timer_beat_t pending [$];
		int          errors;

		function new();
			now = '0;
			errors = 0;
			for (int i = 0; i < stq_pkg::SLOTS; i++) begin
				trig[i] = '0;
				per[i] = '0;
				rep[i] = 0;
				armed[i] = 0;
			end
		endfunction

		function void dequeue(int s);
			foreach (order[i]) begin
				if (order[i] == s) begin
					order.delete(i);
					return;
				end
			end
		endfunction

		// insert behind every slot with trigger <= ours
		function void enqueue(int s);
			int pos;
			pos = 0;
			while (pos < order.size() && trig[order[pos]] <= trig[s])
				pos++;
			order.insert(pos, s);
		endfunction

		function void push_beat(bit k, int s, logic [31:0] t);
			timer_beat_t b;
			b.kind = k;
			b.fired_slot = s[3:0];
			b.time_value = t;
			b.last = 0;
			pending.push_back(b);
		endfunction

		// note an accepted command beat
		function void note_command(stq_pkg::opcode_t op, int s, logic [23:0] d, bit r);
			bit fired [stq_pkg::SLOTS];
			int n;
			int h;
			n = 0;
			for (int i = 0; i < stq_pkg::SLOTS; i++)
				fired[i] = 0;
			case (op)
				stq_pkg::OP_TICK: begin
					now = now + 1;
					while (n < stq_pkg::MAX_OUT && order.size() > 0) begin
						h = order[0];
						if (fired[h] || trig[h] > now)
							break;
						fired[h] = 1;
						order.delete(0);
						push_beat(0, h, now);
						n++;
						if (rep[h]) begin
							trig[h] = trig[h] + per[h];
							enqueue(h);
						end else begin
							armed[h] = 0;
						end
					end
				end
				stq_pkg::OP_START: begin
					if (armed[s])
						dequeue(s);
					per[s] = d;
					rep[s] = r;
					armed[s] = 1;
					trig[s] = now + d;
					enqueue(s);
				end
				stq_pkg::OP_STOP: begin
					if (armed[s]) begin
						dequeue(s);
						armed[s] = 0;
					end
				end
				default: begin
					push_beat(1, 0, now);
					n = 1;
				end
			endcase
			if (n > 0)
				pending[pending.size() - 1].last = 1;
		endfunction

		// compare one accepted result beat against the oldest expectation
		function void check_beat(timer_beat_t act);
			timer_beat_t exp_b;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, act);
				errors++;
				return;
			end
			exp_b = pending.pop_front();
			if (act.kind !== exp_b.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, exp_b.kind, act.kind);
				errors++;
			end
			if (act.fired_slot !== exp_b.fired_slot) begin
				$display("%0t: fired_slot expected %0d actual %0d", $time,
					exp_b.fired_slot, act.fired_slot);
				errors++;
			end
			if (act.time_value !== exp_b.time_value) begin
				$display("%0t: time_value expected %0d actual %0d", $time,
					exp_b.time_value, act.time_value);
				errors++;
			end
			if (act.last !== exp_b.last) begin
				$display("%0t: last expected %0d actual %0d", $time, exp_b.last, act.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [3:0]  slot;
	logic [23:0] delta;
	logic        repeat_req;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [3:0]  fired_slot;
	logic [31:0] time_value;
	logic        last;

	timer_scoreboard sb;
	bit              rx_busy_mode;

	sorted_timer_queue_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.slot       (slot),
		.delta      (delta),
		.repeat_req (repeat_req),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.fired_slot (fired_slot),
		.time_value (time_value),
		.last       (last)
	);

	// clock
	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// send one command beat after a random gap (none with no_gap); valid stays up until the
	// next call drops it for a gap or drain_wait drops it
	task automatic send_cmd(stq_pkg::opcode_t op, int s, logic [23:0] d, bit r,
		bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		slot <= s[3:0];
		delta <= d;
		repeat_req <= r;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_command(op, s, d, r);
	endtask

	task automatic drain_wait();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// receiver: sample beats at the edge, draw a stall length per beat
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_beat('{kind, fired_slot, time_value, last});
				hold = rx_busy_mode ? $urandom_range(0, 8) : 0;
				if (hold > 0) begin
					out_stall <= 1;
					repeat (hold) @(posedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	// stimulus
	initial begin
		int roll;
		int s;
		sb = new();
		rx_busy_mode = 1;
		arst_n = 0;
		in_valid = 0;
		opcode = stq_pkg::OP_TICK;
		slot = '0;
		delta = '0;
		repeat_req = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty tick, read, extremes, stop of idle slot, restart
		send_cmd(stq_pkg::OP_TICK, 0, 24'd0, 0);
		send_cmd(stq_pkg::OP_READ, 15, 24'hFFFFFF, 1);
		send_cmd(stq_pkg::OP_STOP, 7, 24'd5, 0);
		send_cmd(stq_pkg::OP_START, 0, 24'd1, 0);
		send_cmd(stq_pkg::OP_START, 15, 24'd1, 1);
		send_cmd(stq_pkg::OP_START, 3, 24'd2, 0);
		send_cmd(stq_pkg::OP_START, 3, 24'd1, 1);
		send_cmd(stq_pkg::OP_TICK, 0, 24'd0, 0);
		send_cmd(stq_pkg::OP_TICK, 0, 24'd0, 0);
		send_cmd(stq_pkg::OP_STOP, 15, 24'd0, 0);
		send_cmd(stq_pkg::OP_STOP, 3, 24'd0, 0);
		send_cmd(stq_pkg::OP_START, 9, 24'hFFFFFF, 1);
		send_cmd(stq_pkg::OP_START, 10, 24'h800000, 0);
		send_cmd(stq_pkg::OP_READ, 0, 24'd0, 0);
		drain_wait();
		// all sixteen slots due at once
		for (int i = 0; i < stq_pkg::SLOTS; i++)
			send_cmd(stq_pkg::OP_START, i, 24'd1, i[0], 1);
		send_cmd(stq_pkg::OP_TICK, 0, 24'd0, 0);
		send_cmd(stq_pkg::OP_TICK, 0, 24'd0, 0);
		drain_wait();

		// random: mostly short delays so timers fire, some long ones
		for (int i = 0; i < 410; i++) begin
			if (i == 150)
				rx_busy_mode = 0;
			if (i == 250)
				rx_busy_mode = 1;
			if (i == 200)
				drain_wait();
			roll = $urandom_range(0, 99);
			s = $urandom_range(0, 15);
			if (roll < 45)
				send_cmd(stq_pkg::OP_TICK, s, 24'($urandom), 1'($urandom));
			else if (roll < 75)
				send_cmd(stq_pkg::OP_START, s, ($urandom_range(0, 9) == 0) ?
					24'($urandom) | 24'h1 : 24'($urandom_range(1, 6)), 1'($urandom));
			else if (roll < 88)
				send_cmd(stq_pkg::OP_STOP, s, 24'($urandom), 1'($urandom));
			else
				send_cmd(stq_pkg::OP_READ, s, 24'($urandom), 1'($urandom));
		end

		drain_wait();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sorted_timer_queue_unit regression: pass");
		else
			$display("sorted_timer_queue_unit regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("sorted_timer_queue_unit regression: fail");
		$finish;
	end

endmodule
